>>> design/zid_pkg.sv
// ---------------------------------------------------------------------------
// zid_pkg
// Shared types and constants for the zone intrusion detector.
// ---------------------------------------------------------------------------
package zid_pkg;

  localparam int FOOT_W  = 21;
  localparam int COORD_W = 16;
  localparam int TRACK_W = 8;
  localparam int VIDX_W  = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_DEPTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_TOTAL  = 1'd1;

  localparam logic FUNC_OBSERVE = 1'b0;
  localparam logic FUNC_VERTEX  = 1'b1;

  localparam logic [4:0] HISTORY_DEPTH_RESET = 5'd5;
  localparam logic [6:0] VERTEX_TOTAL_RESET  = 7'd0;
  localparam int ALARM_THRESHOLD = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EDGE,
    ST_HIST,
    ST_OUT
  } zid_state_t;

  // Status from the zone walker to the top level
  typedef struct packed {
    logic busy;
    logic done;
    logic hit;
  } zid_walk_stat_t;

endpackage

>>> design/zid_if.sv
// ---------------------------------------------------------------------------
// zid_in_if / zid_out_if / zid_cfg_if
// Valid/ready channels of the zone intrusion detector.
// ---------------------------------------------------------------------------
interface zid_in_if import zid_pkg::*; ();
  logic valid;
  logic ready;
  logic func;
  logic [TRACK_W-1:0] track_id;
  logic signed [FOOT_W-1:0] left_foot_x;
  logic signed [FOOT_W-1:0] left_foot_y;
  logic signed [FOOT_W-1:0] right_foot_x;
  logic signed [FOOT_W-1:0] right_foot_y;
  logic [VIDX_W-1:0] vertex_index;
  logic [COORD_W-1:0] vertex_x;
  logic [COORD_W-1:0] vertex_y;
  logic closes_zone;
  modport source (output valid, func, track_id, left_foot_x, left_foot_y, right_foot_x,
                  right_foot_y, vertex_index, vertex_x, vertex_y, closes_zone,
                  input ready);
  modport sink (input valid, func, track_id, left_foot_x, left_foot_y, right_foot_x,
                right_foot_y, vertex_index, vertex_x, vertex_y, closes_zone,
                output ready);
endinterface

interface zid_out_if import zid_pkg::*; ();
  logic valid;
  logic ready;
  logic [TRACK_W-1:0] result_track;
  logic in_zone;
  logic [4:0] in_zone_count;
  logic alarm;
  modport source (output valid, result_track, in_zone, in_zone_count, alarm, input ready);
  modport sink (input valid, result_track, in_zone, in_zone_count, alarm, output ready);
endinterface

interface zid_cfg_if import zid_pkg::*; ();
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/zone_intrusion_detector_top.sv
// ---------------------------------------------------------------------------
// zone_intrusion_detector_top
// Zone intrusion detector with per-track history vote.
// ---------------------------------------------------------------------------
// Channels: inp (items), res (results), cfg (register writes).
// A vertex-write transaction is stored when accepted and gives no result.
// An observation walks the vertex memory slot by slot, each slot read
// through the registered read port before its edge is tested, with a
// wrap edge per zone; the walk is set by the single vertex memory read
// port. A history read-modify-write follows.
// After reset a clearing pass empties every entry of the history
// memory; no item is accepted during it, configuration is taken.
// A result waits in the output register while the receiver stalls;
// the next item is accepted only after it has been taken.
// Track ids at or above TRACK_COUNT produce no result and no change.
// ---------------------------------------------------------------------------
module zone_intrusion_detector_top import zid_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int TRACK_COUNT  = 256,
  parameter int MAX_HISTORY  = 16
) (
  input logic clk,
  input logic rst,
  zid_in_if.sink   inp,
  zid_out_if.source res,
  zid_cfg_if.sink  cfg
);
  logic [4:0] depth_cfg;
  logic [6:0] vtotal_cfg;
  zid_state_t state, state_next;
  zid_walk_stat_t ws;
  logic clearing, acc, obs_ok, hit_r;
  logic [TRACK_W-1:0] trk;
  logic signed [FOOT_W-1:0] lx, ly, rx, ry;
  logic [4:0] cnt;

  // Configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_cfg <= HISTORY_DEPTH_RESET; vtotal_cfg <= VERTEX_TOTAL_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_HISTORY_DEPTH: depth_cfg <= cfg.data[4:0];
        REG_VERTEX_TOTAL:  vtotal_cfg <= cfg.data;
        default: ;
      endcase
    end
  end

  assign inp.ready = (state == ST_IDLE) && !clearing;
  assign acc = inp.valid && inp.ready;
  assign obs_ok = (inp.func == FUNC_OBSERVE) && (32'(inp.track_id) < TRACK_COUNT);

  always_ff @(posedge clk) begin
    if (acc && obs_ok) begin
      trk <= inp.track_id;
      lx <= inp.left_foot_x; ly <= inp.left_foot_y;
      rx <= inp.right_foot_x; ry <= inp.right_foot_y;
    end
    if (ws.done) hit_r <= ws.hit;
  end

  zid_walker #(.MAX_VERTICES(MAX_VERTICES)) u_walk (
    .clk, .rst,
    .wr_en(acc && inp.func == FUNC_VERTEX), .wr_idx(inp.vertex_index),
    .wr_x(inp.vertex_x), .wr_y(inp.vertex_y), .wr_last(inp.closes_zone),
    .start(state == ST_READ), .vtotal(vtotal_cfg),
    .lx, .ly, .rx, .ry, .stat(ws)
  );

  zid_history #(.TRACK_COUNT(TRACK_COUNT), .MAX_HISTORY(MAX_HISTORY)) u_hist (
    .clk, .rst, .rd_en(acc), .rd_track(inp.track_id),
    .upd_en(state == ST_HIST), .hit(hit_r), .depth_cfg, .clearing, .count(cnt)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (acc && obs_ok) state_next = ST_READ;
      ST_READ: state_next = ST_EDGE;
      ST_EDGE: if (ws.done) state_next = ST_HIST;
      ST_HIST: state_next = ST_OUT;
      ST_OUT:  if (res.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Outputs
  always_comb begin
    res.valid = (state == ST_OUT);
    res.result_track = trk;
    res.in_zone = hit_r;
    res.in_zone_count = cnt;
    res.alarm = (cnt >= 5'(ALARM_THRESHOLD));
  end

  a_out: assert property (@(posedge clk) disable iff (rst) res.valid && !res.ready |=> res.valid)
    else $error("result dropped under stall");
  a_busy: assert property (@(posedge clk) disable iff (rst) state == ST_EDGE |-> !inp.ready)
    else $error("input ready during walk");
  a_clr: assert property (@(posedge clk) disable iff (rst) clearing |-> state == ST_IDLE)
    else $error("item in flight during clearing");
endmodule

>>> design/zid_walker.sv
// ---------------------------------------------------------------------------
// zid_walker
// Vertex memory and edge walker: tests both feet against every closed zone of three or more vertices.
// ---------------------------------------------------------------------------
module zid_walker import zid_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  logic [VIDX_W-1:0] wr_idx,
  input  logic [COORD_W-1:0] wr_x,
  input  logic [COORD_W-1:0] wr_y,
  input  logic wr_last,
  input  logic start,
  input  logic [6:0] vtotal,
  input  logic signed [FOOT_W-1:0] lx,
  input  logic signed [FOOT_W-1:0] ly,
  input  logic signed [FOOT_W-1:0] rx,
  input  logic signed [FOOT_W-1:0] ry,
  output zid_walk_stat_t stat
);
  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int MW = COORD_W + 5;   // scaled vertex, signed
  localparam int DW = MW + 1;        // differences
  localparam int PW = 2 * DW;        // products

  logic [COORD_W*2:0] mem [MAX_VERTICES];
  logic [COORD_W*2:0] rd;

  // Walk control
  logic busy, rd_pend, have_first, hit, in_l, in_r, on_l, on_r, done;
  logic [CW-1:0] n, ptr, zcount;
  logic [AW-1:0] first_idx;
  logic [COORD_W-1:0] px, py, fx, fy;
  logic closing;   // current edge wraps back to first vertex
  logic [CW-1:0] limit;

  assign limit = (32'(vtotal) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vtotal);

  // Memory: one write port, one registered read
  logic [AW-1:0] rd_addr;
  assign rd_addr = ptr[AW-1:0];
  always_ff @(posedge clk) begin
    if (wr_en && (32'(wr_idx) < MAX_VERTICES)) mem[AW'(wr_idx)] <= {wr_last, wr_x, wr_y};
    rd <= mem[rd_addr];
  end

  // Edge test, one edge at a time. Edge a->b, a = previous, b = current or first
  logic signed [MW-1:0] ax, ay, bx, by;
  logic signed [DW-1:0] dbx, dby, dlx, dly, drx, dry;
  logic signed [PW-1:0] tl, tr;
  logic cur_last;
  logic [COORD_W-1:0] cx, cy;
  assign cur_last = rd[COORD_W*2];
  assign cx = closing ? fx : rd[COORD_W*2-1:COORD_W];
  assign cy = closing ? fy : rd[COORD_W-1:0];
  assign ax = $signed({1'b0, px, 4'b0});
  assign ay = $signed({1'b0, py, 4'b0});
  assign bx = $signed({1'b0, cx, 4'b0});
  assign by = $signed({1'b0, cy, 4'b0});
  assign dbx = DW'(bx) - DW'(ax);
  assign dby = DW'(by) - DW'(ay);
  assign dlx = DW'(lx) - DW'(ax);
  assign dly = DW'(ly) - DW'(ay);
  assign drx = DW'(rx) - DW'(ax);
  assign dry = DW'(ry) - DW'(ay);
  assign tl = dly * dbx - dlx * dby;
  assign tr = dry * dbx - drx * dby;

  function automatic logic on_seg(input logic signed [PW-1:0] t,
      input logic signed [MW-1:0] x, y, a_x, a_y, b_x, b_y);
    logic signed [MW-1:0] lo_x, hi_x, lo_y, hi_y;
    lo_x = (a_x < b_x) ? a_x : b_x; hi_x = (a_x < b_x) ? b_x : a_x;
    lo_y = (a_y < b_y) ? a_y : b_y; hi_y = (a_y < b_y) ? b_y : a_y;
    return (t == '0) && x >= lo_x && x <= hi_x && y >= lo_y && y <= hi_y;
  endfunction

  function automatic logic crosses(input logic signed [PW-1:0] t,
      input logic signed [MW-1:0] y, a_y, b_y);
    return ((a_y > y) != (b_y > y)) && ((b_y > a_y) ? (t > 0) : (t < 0));
  endfunction

  logic signed [MW-1:0] lxm, lym, rxm, rym;
  assign lxm = MW'(lx); assign lym = MW'(ly);
  assign rxm = MW'(rx); assign rym = MW'(ry);

  logic edge_ok;   // an edge is evaluated this cycle
  assign edge_ok = busy && !rd_pend && (have_first || closing) && zcount != '0;

  // Sequencer: ptr walks slots; closing inserts a wrap edge after a last flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0; rd_pend <= 1'b0; closing <= 1'b0;
      hit <= 1'b0; ptr <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1; hit <= 1'b0; ptr <= '0; rd_pend <= 1'b1;
        closing <= 1'b0; have_first <= 1'b0; zcount <= '0;
        in_l <= 1'b0; in_r <= 1'b0; on_l <= 1'b0; on_r <= 1'b0;
        n <= limit;
      end else if (busy) begin
        if (ptr >= n && !closing) begin
          busy <= 1'b0; done <= 1'b1;
        end else if (rd_pend) begin
          rd_pend <= 1'b0;
        end else if (closing) begin
          // wrap edge done, close zone
          if (zcount >= CW'(3) &&
              (on_l || on_r || in_l != crosses(tl, lym, ay, by) ||
               in_r != crosses(tr, rym, ay, by) ||
               on_seg(tl, lxm, lym, ax, ay, bx, by) ||
               on_seg(tr, rxm, rym, ax, ay, bx, by)))
            hit <= 1'b1;
          closing <= 1'b0; have_first <= 1'b0; zcount <= '0;
          in_l <= 1'b0; in_r <= 1'b0; on_l <= 1'b0; on_r <= 1'b0;
          rd_pend <= 1'b1;
        end else begin
          if (!have_first) begin
            fx <= cx; fy <= cy; have_first <= 1'b1;
          end else begin
            if (crosses(tl, lym, ay, by)) in_l <= !in_l;
            if (crosses(tr, rym, ay, by)) in_r <= !in_r;
            if (on_seg(tl, lxm, lym, ax, ay, bx, by)) on_l <= 1'b1;
            if (on_seg(tr, rxm, rym, ax, ay, bx, by)) on_r <= 1'b1;
          end
          px <= cx; py <= cy;
          zcount <= zcount + CW'(1);
          ptr <= ptr + CW'(1);
          if (cur_last) closing <= 1'b1;
          else rd_pend <= 1'b1;
        end
      end
    end
  end

  // edge_ok is informational on walk progress
  logic unused_ok;
  assign unused_ok = edge_ok;

  assign stat.busy = busy || unused_ok;
  assign stat.done = done;
  assign stat.hit  = hit;

  // A walk never reads beyond the saturated vertex count
  a_ptr: assert property (@(posedge clk) disable iff (rst) busy |-> ptr <= n)
    else $error("walker pointer overran vertex count");
  a_done: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("walker done while busy");
  a_start: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("walker failed to start");
endmodule

>>> design/zid_history.sv
// ---------------------------------------------------------------------------
// zid_history
// Per-track history memory with read-modify-write and clearing pass.
// ---------------------------------------------------------------------------
module zid_history import zid_pkg::*; #(
  parameter int TRACK_COUNT = 256,
  parameter int MAX_HISTORY = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic rd_en,
  input  logic [TRACK_W-1:0] rd_track,
  input  logic upd_en,
  input  logic hit,
  input  logic [4:0] depth_cfg,
  output logic clearing,
  output logic [4:0] count
);
  localparam int TW = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
  localparam int LW = $clog2(MAX_HISTORY + 1);

  logic [MAX_HISTORY+LW-1:0] mem [TRACK_COUNT];
  logic [MAX_HISTORY+LW-1:0] rd;
  logic [TW-1:0] addr, clr_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1; clr_ptr <= '0;
    end else if (clearing) begin
      clr_ptr <= clr_ptr + TW'(1);
      if (clr_ptr == TW'(TRACK_COUNT - 1)) clearing <= 1'b0;
    end
  end

  // Update: shift in hit, clamp length to depth
  logic [LW:0] depth, len;
  logic [MAX_HISTORY-1:0] bits, mask;
  assign depth = (32'(depth_cfg) > MAX_HISTORY) ? (LW+1)'(MAX_HISTORY) : (LW+1)'(depth_cfg);
  assign len = ((LW+1)'(rd[LW-1:0]) + (LW+1)'(1) > depth) ? depth
               : (LW+1)'(rd[LW-1:0]) + (LW+1)'(1);
  always_comb begin
    for (int k = 0; k < MAX_HISTORY; k++) mask[k] = (k < int'(len));
  end
  assign bits = {rd[MAX_HISTORY+LW-2:LW], hit} & mask;

  always_ff @(posedge clk) begin
    if (rd_en) addr <= TW'(rd_track);
    if (clearing) mem[clr_ptr] <= '0;
    else if (upd_en) mem[addr] <= {bits, len[LW-1:0]};
    rd <= mem[rd_en ? TW'(rd_track) : addr];
  end

  always_ff @(posedge clk) begin
    if (upd_en) count <= 5'($countones(bits));
  end

  a_clr: assert property (@(posedge clk) disable iff (rst) clearing |-> !upd_en)
    else $error("history update during clearing pass");
  a_len: assert property (@(posedge clk) disable iff (rst) upd_en |-> len <= depth)
    else $error("history length over depth");
  a_cnt: assert property (@(posedge clk) disable iff (rst) $past(upd_en) |-> count <= 5'(MAX_HISTORY))
    else $error("history count over limit");
endmodule

>>> test/zone_intrusion_detector_top_test.sv
// ---------------------------------------------------------------------------
// zone_intrusion_detector_top_test
// Self-checking bench: drives vertex writes and observations with random
// idling, predicts each result with a behavioural zone/history model and
// compares every result transaction field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module zone_intrusion_detector_top_test;
  import zid_pkg::*;

  typedef struct {
    logic [TRACK_W-1:0] track;
    logic               hit;
    logic [4:0]         count;
    logic               alarm;
  } verdict_t;

  // Scoreboard: own copy of vertex memory, history and registers
  class intrusion_scoreboard;
    logic [15:0] vx [64];
    logic [15:0] vy [64];
    logic        vlast [64];
    logic [15:0] hbits [256];
    int          hlen [256];
    int          depth;
    int          vtotal;
    verdict_t    pending [$];
    int          errors;

    function void clear();
      for (int i = 0; i < 64; i++) begin
        vx[i] = '0; vy[i] = '0; vlast[i] = 1'b0;
      end
      for (int i = 0; i < 256; i++) begin
        hbits[i] = '0; hlen[i] = 0;
      end
      depth = HISTORY_DEPTH_RESET; vtotal = VERTEX_TOTAL_RESET;
      pending.delete(); errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_HISTORY_DEPTH) depth = val[4:0];
      else vtotal = val;
    endfunction

    // Inside or on the edge of zone first..last
    function bit point_in(int first, int last, longint px, longint py);
      bit odd;
      int j;
      longint ax, ay, bx, by, t;
      odd = 0;
      for (int i = first; i <= last; i++) begin
        j = (i == last) ? first : i + 1;
        ax = longint'(vx[i]) * 16; ay = longint'(vy[i]) * 16;
        bx = longint'(vx[j]) * 16; by = longint'(vy[j]) * 16;
        t = (py - ay) * (bx - ax) - (px - ax) * (by - ay);
        if (t == 0 && px >= (ax < bx ? ax : bx) && px <= (ax > bx ? ax : bx) &&
            py >= (ay < by ? ay : by) && py <= (ay > by ? ay : by))
          return 1;
        if ((ay > py) != (by > py))
          if ((by > ay) ? (t > 0) : (t < 0)) odd = !odd;
      end
      return odd;
    endfunction

    function void note_item(logic fn, logic [7:0] tid, logic signed [20:0] lx,
                            logic signed [20:0] ly, logic signed [20:0] rx,
                            logic signed [20:0] ry, logic [5:0] vi,
                            logic [15:0] px, logic [15:0] py, logic cl);
      int n, start, d, len, cnt;
      bit hit;
      logic [15:0] bits;
      verdict_t v;
      if (fn == FUNC_VERTEX) begin
        vx[vi] = px; vy[vi] = py; vlast[vi] = cl;
        return;
      end
      n = vtotal > 64 ? 64 : vtotal;
      start = 0; hit = 0;
      for (int i = 0; i < n; i++)
        if (vlast[i]) begin
          if (i - start + 1 >= 3)
            if (point_in(start, i, lx, ly) || point_in(start, i, rx, ry)) hit = 1;
          start = i + 1;
        end
      d = depth > 16 ? 16 : depth;
      len = hlen[tid] + 1;
      if (len > d) len = d;
      bits = {hbits[tid][14:0], hit};
      for (int k = 0; k < 16; k++) if (k >= len) bits[k] = 1'b0;
      hbits[tid] = bits; hlen[tid] = len;
      cnt = $countones(bits);
      v.track = tid; v.hit = hit; v.count = 5'(cnt); v.alarm = cnt >= ALARM_THRESHOLD;
      pending = {pending, v};
    endfunction

    function void check_result(logic [7:0] tr, logic hz, logic [4:0] c, logic al);
      verdict_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result track %0d", $time, tr);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (tr !== e.track || hz !== e.hit || c !== e.count || al !== e.alarm) begin
        $display("%0t: mismatch expected trk=%0d in=%0d cnt=%0d alm=%0d",
                 $time, e.track, e.hit, e.count, e.alarm);
        $display("%0t:          actual   trk=%0d in=%0d cnt=%0d alm=%0d",
                 $time, tr, hz, c, al);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  zid_in_if  inp ();
  zid_out_if res ();
  zid_cfg_if cfg ();

  zone_intrusion_detector_top i_dut (
    .clk(clk), .rst(rst), .inp(inp.sink), .res(res.source), .cfg(cfg.sink)
  );

  intrusion_scoreboard board;
  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("zone_intrusion_detector_top verification failed");
    $finish;
  end

  // Result side: stall at random, check every accepted result
  initial begin
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res.valid && res.ready)
        board.check_result(res.result_track, res.in_zone, res.in_zone_count, res.alarm);
      @(negedge clk);
      if (recv_hold > 0) begin
        recv_hold--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    inp.valid <= 1'b0;
    cfg.index <= idx; cfg.data <= val; cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Offers one item after random idling at falling edges; valid stays up after the
  // accepting edge until the next driving task takes the inputs over
  task automatic send_item(logic fn, logic [7:0] tid, logic signed [20:0] lx,
                           logic signed [20:0] ly, logic signed [20:0] rx,
                           logic signed [20:0] ry, logic [5:0] vi,
                           logic [15:0] px, logic [15:0] py, logic cl);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      inp.valid <= 1'b0;
      @(negedge clk);
    end
    inp.func <= fn; inp.track_id <= tid;
    inp.left_foot_x <= lx; inp.left_foot_y <= ly;
    inp.right_foot_x <= rx; inp.right_foot_y <= ry;
    inp.vertex_index <= vi; inp.vertex_x <= px; inp.vertex_y <= py;
    inp.closes_zone <= cl; inp.valid <= 1'b1;
    do @(posedge clk); while (!inp.ready);
    board.note_item(fn, tid, lx, ly, rx, ry, vi, px, py, cl);
  endtask

  task automatic put_vertex(int slot, int x, int y, bit cl);
    send_item(FUNC_VERTEX, 8'($urandom), 21'($urandom), 21'($urandom), 21'($urandom),
              21'($urandom), 6'(slot), 16'(x), 16'(y), cl);
  endtask

  task automatic observe(logic [7:0] tid, int lx, int ly, int rx, int ry);
    send_item(FUNC_OBSERVE, tid, 21'(lx), 21'(ly), 21'(rx), 21'(ry), 6'($urandom),
              16'($urandom), 16'($urandom), 1'($urandom));
  endtask

  // Wait for every result, then let the walker settle
  task automatic drain();
    int guard;
    guard = 0;
    @(negedge clk);
    inp.valid <= 1'b0;
    while (board.pending.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (300) @(negedge clk);
  endtask

  // Random zone layout: count vertices, random zone sizes, all slots written
  task automatic build_zones(int count);
    int left, sz, base;
    base = 0;
    while (base < count) begin
      left = count - base;
      sz = $urandom_range(left < 6 ? left : 6, 1);
      for (int i = 0; i < sz; i++)
        put_vertex(base + i, $urandom_range(65535) >> $urandom_range(9, 0),
                   $urandom_range(65535) >> $urandom_range(9, 0), i == sz - 1);
      base += sz;
    end
  endtask

  // Foot near a stored vertex so hits, edges and corners all occur
  function automatic int near_foot(bit is_x);
    int slot, base;
    if (board.vtotal == 0 || $urandom_range(9) == 0)
      return $signed(21'($urandom));
    slot = $urandom_range((board.vtotal > 64 ? 64 : board.vtotal) - 1);
    base = (is_x ? board.vx[slot] : board.vy[slot]) * 16;
    if (base > 1048575) base = 1048575;
    case ($urandom_range(2))
      0: return base;
      1: return base + $signed($urandom_range(64)) - 32;
      default: return base + $signed($urandom_range(8000)) - 4000;
    endcase
  endfunction

  task automatic random_phase(int items, int vcount);
    build_zones(vcount);
    write_reg(REG_VERTEX_TOTAL, 7'(vcount));
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(19) == 0)
        put_vertex($urandom_range(vcount > 0 ? vcount - 1 : 0),
                   $urandom_range(65535), $urandom_range(65535), $urandom_range(1));
      else
        observe(8'($urandom_range(7) == 0 ? $urandom_range(255) : $urandom_range(7)),
                near_foot(1), near_foot(0), near_foot(1), near_foot(0));
    end
    drain();
  endtask

  initial begin
    board = new();
    board.clear();
    send_idle_pct = 0; recv_idle_pct = 0; recv_hold = 0;
    inp.valid = 1'b0; inp.func = FUNC_OBSERVE; inp.track_id = '0;
    inp.left_foot_x = '0; inp.left_foot_y = '0;
    inp.right_foot_x = '0; inp.right_foot_y = '0;
    inp.vertex_index = '0; inp.vertex_x = '0; inp.vertex_y = '0;
    inp.closes_zone = 1'b0;
    cfg.valid = 1'b0; cfg.index = REG_HISTORY_DEPTH; cfg.data = '0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: no zones, then a square, a two-vertex zone and an open tail
    observe(8'd0, 0, 0, 0, 0);
    put_vertex(0, 10, 10, 0); put_vertex(1, 20, 10, 0);
    put_vertex(2, 20, 20, 0); put_vertex(3, 10, 20, 1);
    put_vertex(4, 0, 0, 0);   put_vertex(5, 65535, 65535, 1);
    put_vertex(6, 65535, 0, 0);
    put_vertex(63, 1, 1, 1);
    write_reg(REG_VERTEX_TOTAL, 7'd7);
    observe(8'd1, 15 * 16, 15 * 16, -1048576, -1048576);
    observe(8'd1, 10 * 16, 12 * 16, 1048575, 1048575);
    observe(8'd1, 1048575, -1048576, 20 * 16, 20 * 16);
    observe(8'd1, 10 * 16 - 1, 15 * 16, 0, 0);
    observe(8'd255, 32000 * 16 / 2, 32000 * 16 / 2, 0, 0);
    observe(8'd1, 20 * 16 + 1, 15 * 16, 15 * 16, 15 * 16);
    observe(8'd1, 15 * 16, 15 * 16, 15 * 16, 15 * 16);
    drain();
    write_reg(REG_HISTORY_DEPTH, 7'd31);
    for (int i = 0; i < 4; i++) observe(8'd1, 15 * 16, 15 * 16, 0, 0);
    drain();
    write_reg(REG_HISTORY_DEPTH, 7'd2);
    observe(8'd1, 15 * 16, 15 * 16, 0, 0);
    drain();
    // Fill the remaining slots so a saturated vertex count reads written data
    for (int s = 7; s < 63; s++) put_vertex(s, 0, 0, 0);
    write_reg(REG_VERTEX_TOTAL, 7'd127);
    drain();
    write_reg(REG_HISTORY_DEPTH, 7'd0);
    observe(8'd1, 15 * 16, 15 * 16, 0, 0);
    drain();

    // Random phases through the idling patterns and register settings
    write_reg(REG_HISTORY_DEPTH, 7'd16);
    send_idle_pct = 15; recv_idle_pct = 73;
    random_phase(250, 64);
    write_reg(REG_HISTORY_DEPTH, 7'd3);
    random_phase(250, 12);
    send_idle_pct = 73; recv_idle_pct = 15;
    write_reg(REG_HISTORY_DEPTH, 7'd5);
    random_phase(300, 20);
    write_reg(REG_HISTORY_DEPTH, 7'd1);
    random_phase(150, 8);
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_HISTORY_DEPTH, 7'd16);
    random_phase(300, 30);

    // Long receiver hold-off while items keep coming
    recv_hold = 400;
    random_phase(100, 10);
    write_reg(REG_HISTORY_DEPTH, 7'd9);
    random_phase(250, 40);
    write_reg(REG_VERTEX_TOTAL, 7'd0);
    observe(8'd3, 0, 0, 0, 0);
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("zone_intrusion_detector_top verification clean");
    end else begin
      $display("zone_intrusion_detector_top verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/zid_pkg.sv
design/zid_if.sv
design/zid_walker.sv
design/zid_history.sv
design/zone_intrusion_detector_top.sv
test/zone_intrusion_detector_top_test.sv
